### src/siex_pkg.sv
// shared types, opcode codes and helpers for the scalar integer execute unit
package siex_pkg;

  localparam int unsigned ImemAddrBits = 12;
  localparam logic [ImemAddrBits-1:0] PcMask = {{(ImemAddrBits-2){1'b1}}, 2'b00};

  // primary opcodes
  localparam logic [5:0] OpSpecial = 6'h00;
  localparam logic [5:0] OpRegimm  = 6'h01;
  localparam logic [5:0] OpJ       = 6'h02;
  localparam logic [5:0] OpJal     = 6'h03;
  localparam logic [5:0] OpBeq     = 6'h04;
  localparam logic [5:0] OpBne     = 6'h05;
  localparam logic [5:0] OpBlez    = 6'h06;
  localparam logic [5:0] OpBgtz    = 6'h07;
  localparam logic [5:0] OpAddi    = 6'h08;
  localparam logic [5:0] OpAddiu   = 6'h09;
  localparam logic [5:0] OpSlti    = 6'h0A;
  localparam logic [5:0] OpSltiu   = 6'h0B;
  localparam logic [5:0] OpAndi    = 6'h0C;
  localparam logic [5:0] OpOri     = 6'h0D;
  localparam logic [5:0] OpXori    = 6'h0E;
  localparam logic [5:0] OpLui     = 6'h0F;
  localparam logic [5:0] OpLb      = 6'h20;
  localparam logic [5:0] OpLh      = 6'h21;
  localparam logic [5:0] OpLw      = 6'h23;
  localparam logic [5:0] OpLbu     = 6'h24;
  localparam logic [5:0] OpLhu     = 6'h25;
  localparam logic [5:0] OpSb      = 6'h28;
  localparam logic [5:0] OpSh      = 6'h29;
  localparam logic [5:0] OpSw      = 6'h2B;

  // special funct codes
  localparam logic [5:0] FnSll  = 6'h00;
  localparam logic [5:0] FnSrl  = 6'h02;
  localparam logic [5:0] FnSra  = 6'h03;
  localparam logic [5:0] FnSllv = 6'h04;
  localparam logic [5:0] FnSrlv = 6'h06;
  localparam logic [5:0] FnSrav = 6'h07;
  localparam logic [5:0] FnJr   = 6'h08;
  localparam logic [5:0] FnJalr = 6'h09;
  localparam logic [5:0] FnBrk  = 6'h0D;
  localparam logic [5:0] FnAdd  = 6'h20;
  localparam logic [5:0] FnAddu = 6'h21;
  localparam logic [5:0] FnSub  = 6'h22;
  localparam logic [5:0] FnSubu = 6'h23;
  localparam logic [5:0] FnAnd  = 6'h24;
  localparam logic [5:0] FnOr   = 6'h25;
  localparam logic [5:0] FnXor  = 6'h26;
  localparam logic [5:0] FnNor  = 6'h27;
  localparam logic [5:0] FnSlt  = 6'h2A;
  localparam logic [5:0] FnSltu = 6'h2B;

  localparam logic [4:0] LinkReg = 5'd31;

  // alu operation selected in decode
  typedef enum logic [3:0] {
    AluAdd, AluSub, AluAnd, AluOr, AluXor, AluNor, AluSlt, AluSltu,
    AluSll, AluSrl, AluSra, AluPassB, AluPassLink
  } alu_op_e;

  // branch condition selected in decode
  typedef enum logic [2:0] {
    BrNone, BrAlways, BrEq, BrNe, BrLez, BrGtz, BrLtz, BrGez
  } br_cond_e;

  typedef struct packed {
    logic [31:0] result_value;
    logic [4:0]  dest_register;
    logic        branch_taken;
    logic [ImemAddrBits-1:0] branch_target;
    logic        mem_request;
    logic [31:0] mem_address;
    logic [31:0] store_data;
    logic [31:0] extend_mask;
    logic [31:0] write_mask;
    logic [4:0]  lane_shift;
    logic        halt_request;
    logic        illegal_op;
  } result_t;

  typedef struct packed {
    logic [31:0] instruction;
    logic [31:0] source_value;
    logic [31:0] target_value;
    logic [ImemAddrBits-1:0] current_pc;
  } request_t;

  // decoded operation carried from decode to execute
  typedef struct packed {
    alu_op_e     alu_op;
    br_cond_e    br_cond;
    logic        jump_reg;
    logic [31:0] opa;
    logic [31:0] opb;
    logic [4:0]  shamt;
    logic [4:0]  dest;
    logic [ImemAddrBits-1:0] link;
    logic [ImemAddrBits-1:0] br_target;
    logic        mem;
    logic        store;
    logic [31:0] offset;
    logic [31:0] ext_mask;
    logic [4:0]  lshift;
    logic        halt;
    logic        illegal;
  } dec_t;

endpackage

### src/siex_stream_if.sv
// valid/ready channel carrying one payload
interface siex_stream_if #(type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### src/siex_decode.sv
// decode stage: instruction fields to control and operands
module siex_decode (
  input  siex_pkg::request_t req_i,
  output siex_pkg::dec_t     dec_o
);
  import siex_pkg::*;

  logic [5:0]  op, fn;
  logic [4:0]  rtf, rdf, sa;
  logic [31:0] imm_s, imm_z, rs, rt;
  logic [ImemAddrBits-1:0] pc;
  logic [4:0]  mshift;

  assign op    = req_i.instruction[31:26];
  assign fn    = req_i.instruction[5:0];
  assign rtf   = req_i.instruction[20:16];
  assign rdf   = req_i.instruction[15:11];
  assign sa    = req_i.instruction[10:6];
  assign imm_s = {{16{req_i.instruction[15]}}, req_i.instruction[15:0]};
  assign imm_z = {16'h0, req_i.instruction[15:0]};
  assign rs    = req_i.source_value;
  assign rt    = req_i.target_value;
  assign pc    = req_i.current_pc;
  assign mshift = {~op[1:0], 3'b000};

  // control decode
  always_comb begin
    dec_o = '0;
    dec_o.alu_op  = AluAdd;
    dec_o.br_cond = BrNone;
    dec_o.opa  = rs;
    dec_o.opb  = rt;
    dec_o.shamt = sa;
    dec_o.link = (pc + ImemAddrBits'(8)) & PcMask;
    dec_o.br_target = (pc + ImemAddrBits'(4) + ImemAddrBits'({imm_s[29:0], 2'b00})) & PcMask;
    dec_o.offset = imm_s;
    case (op)
      OpSpecial: begin
        dec_o.dest = rdf;
        case (fn)
          FnSll: dec_o.alu_op = AluSll;
          FnSrl: dec_o.alu_op = AluSrl;
          FnSra: dec_o.alu_op = AluSra;
          FnSllv: begin
            dec_o.alu_op = AluSll;
            dec_o.shamt  = rs[4:0];
          end
          FnSrlv: begin
            dec_o.alu_op = AluSrl;
            dec_o.shamt  = rs[4:0];
          end
          FnSrav: begin
            dec_o.alu_op = AluSra;
            dec_o.shamt  = rs[4:0];
          end
          FnJr: begin
            dec_o.dest = '0;
            dec_o.br_cond = BrAlways;
            dec_o.jump_reg = 1'b1;
          end
          FnJalr: begin
            dec_o.alu_op = AluPassLink;
            dec_o.br_cond = BrAlways;
            dec_o.jump_reg = 1'b1;
          end
          FnBrk: begin
            dec_o.dest = '0;
            dec_o.halt = 1'b1;
          end
          FnAdd, FnAddu: dec_o.alu_op = AluAdd;
          FnSub, FnSubu: dec_o.alu_op = AluSub;
          FnAnd: dec_o.alu_op = AluAnd;
          FnOr:  dec_o.alu_op = AluOr;
          FnXor: dec_o.alu_op = AluXor;
          FnNor: dec_o.alu_op = AluNor;
          FnSlt: dec_o.alu_op = AluSlt;
          FnSltu: dec_o.alu_op = AluSltu;
          default: dec_o.illegal = 1'b1;
        endcase
      end
      OpRegimm: begin
        if (rtf[3:1] != 3'b000) begin
          dec_o.illegal = 1'b1;
        end else begin
          dec_o.alu_op  = AluPassLink;
          dec_o.dest    = rtf[4] ? LinkReg : 5'd0;
          dec_o.br_cond = rtf[0] ? BrGez : BrLtz;
        end
      end
      OpJ, OpJal: begin
        dec_o.alu_op  = AluPassLink;
        dec_o.dest    = op[0] ? LinkReg : 5'd0;
        dec_o.br_cond = BrAlways;
        dec_o.br_target = {req_i.instruction[ImemAddrBits-3:0], 2'b00};
      end
      OpBeq:  dec_o.br_cond = BrEq;
      OpBne:  dec_o.br_cond = BrNe;
      OpBlez: dec_o.br_cond = BrLez;
      OpBgtz: dec_o.br_cond = BrGtz;
      OpAddi, OpAddiu: begin
        dec_o.dest = rtf;
        dec_o.opb  = imm_s;
      end
      OpSlti: begin
        dec_o.alu_op = AluSlt;
        dec_o.dest = rtf;
        dec_o.opb  = imm_s;
      end
      OpSltiu: begin
        dec_o.alu_op = AluSltu;
        dec_o.dest = rtf;
        dec_o.opb  = imm_s;
      end
      OpAndi: begin
        dec_o.alu_op = AluAnd;
        dec_o.dest = rtf;
        dec_o.opb  = imm_z;
      end
      OpOri: begin
        dec_o.alu_op = AluOr;
        dec_o.dest = rtf;
        dec_o.opb  = imm_z;
      end
      OpXori: begin
        dec_o.alu_op = AluXor;
        dec_o.dest = rtf;
        dec_o.opb  = imm_z;
      end
      OpLui: begin
        dec_o.alu_op = AluPassB;
        dec_o.dest = rtf;
        dec_o.opb  = {req_i.instruction[15:0], 16'h0};
      end
      OpLb, OpLh, OpLw, OpLbu, OpLhu, OpSb, OpSh, OpSw: begin
        dec_o.mem    = 1'b1;
        dec_o.store  = op[3];
        dec_o.dest   = op[3] ? 5'd0 : rtf;
        dec_o.lshift = mshift;
        dec_o.ext_mask = !op[2] ? 32'hFFFF_FFFF :
                         (op[0] ? 32'h0000_FFFF : 32'h0000_00FF);
      end
      default: dec_o.illegal = 1'b1;
    endcase
  end

endmodule

### src/siex_execute.sv
// execute stage: alu, branch compare and memory address
module siex_execute (
  input  siex_pkg::dec_t    dec_i,
  output siex_pkg::result_t res_o
);
  import siex_pkg::*;

  logic [31:0] a, b, alu;
  logic        taken;

  assign a = dec_i.opa;
  assign b = dec_i.opb;

  // alu
  always_comb begin
    case (dec_i.alu_op)
      AluAdd:  alu = a + b;
      AluSub:  alu = a - b;
      AluAnd:  alu = a & b;
      AluOr:   alu = a | b;
      AluXor:  alu = a ^ b;
      AluNor:  alu = ~(a | b);
      AluSlt:  alu = {31'h0, $signed(a) < $signed(b)};
      AluSltu: alu = {31'h0, a < b};
      AluSll:  alu = b << dec_i.shamt;
      AluSrl:  alu = b >> dec_i.shamt;
      AluSra:  alu = 32'($signed(b) >>> dec_i.shamt);
      AluPassB: alu = b;
      AluPassLink: alu = 32'(dec_i.link);
      default: alu = '0;
    endcase
  end

  // branch condition
  always_comb begin
    case (dec_i.br_cond)
      BrAlways: taken = 1'b1;
      BrEq:  taken = (a == b);
      BrNe:  taken = (a != b);
      BrLez: taken = a[31] || (a == '0);
      BrGtz: taken = !(a[31] || (a == '0));
      BrLtz: taken = a[31];
      BrGez: taken = !a[31];
      default: taken = 1'b0;
    endcase
  end

  // result assembly
  always_comb begin
    res_o = '0;
    if (dec_i.illegal) begin
      res_o.illegal_op = 1'b1;
    end else begin
      res_o.dest_register = dec_i.dest;
      res_o.result_value  = (dec_i.dest != '0 && !dec_i.mem) ? alu : '0;
      res_o.branch_taken  = taken;
      if (taken) begin
        res_o.branch_target = dec_i.jump_reg ? (a[ImemAddrBits-1:0] & PcMask)
                                             : dec_i.br_target;
      end
      res_o.halt_request = dec_i.halt;
      if (dec_i.mem) begin
        res_o.mem_request = 1'b1;
        res_o.mem_address = a + dec_i.offset;
        res_o.store_data  = b << dec_i.lshift;
        res_o.extend_mask = dec_i.ext_mask;
        res_o.write_mask  = dec_i.store ? (32'hFFFF_FFFF << dec_i.lshift) : '0;
        res_o.lane_shift  = dec_i.lshift;
      end
    end
  end

endmodule

### src/scalar_integer_execute_unit.sv
// Scalar integer execute unit: three register stages (input, decode, execute
// output), each with its own valid bit and a global stall when the output is
// blocked. One instruction is accepted per cycle while the output is not
// blocked; each accepted request passes the input, decode and execute output
// registers in order before its result is presented, with no loop in between.
module scalar_integer_execute_unit (
  input  logic clk_i,
  input  logic rst_ni,
  siex_stream_if.sink   req,
  siex_stream_if.source rsp
);
  import siex_pkg::*;

  logic     v0_q, v1_q, v2_q;
  request_t r0_q;
  dec_t     d1_q, dec_d;
  result_t  r2_q, res_d;
  logic     adv;

  // the whole pipe moves when the output slot is free or empty
  assign adv = !v2_q || rsp.ready;
  assign req.ready = adv;

  siex_decode u_dec (.req_i(r0_q), .dec_o(dec_d));
  siex_execute u_exe (.dec_i(d1_q), .res_o(res_d));

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv) begin
      v0_q <= req.valid;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      r0_q <= req.payload;
      d1_q <= dec_d;
      r2_q <= res_d;
    end
  end

  assign rsp.valid   = v2_q;
  assign rsp.payload = r2_q;

endmodule
